### rtl/bmhi_pkg.sv
// Package for the binary max-heap insert block.
// Holds field widths, opcode and state enums, and the controller/datapath structs.
// No dependencies.
`default_nettype none

package bmhi_pkg;

  localparam int KEY_W         = 32;
  localparam int TAG_W         = 16;
  localparam int IDX_W         = 4;
  localparam int CNT_W         = 5;
  localparam int OP_W          = 2;
  localparam int DEPTH_DEFAULT = 16;
  localparam int IN_DATA_W     = 56;
  localparam int OUT_DATA_W    = 56;
  localparam int OUT_PAD_W     = OUT_DATA_W - KEY_W - TAG_W - CNT_W;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ_WAIT,
    ST_SIFT,
    ST_PLACE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic write_new;
    logic read_parent;
    logic read_slot;
    logic move_down;
    logic clear;
    logic emit;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic ins_ok;
    logic pos_zero;
    logic parent_zero;
    logic parent_less;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### rtl/binary_max_heap_insert_top.sv
// Top level of the binary max-heap insert block.
// Depends on bmhi_pkg, bmhi_ctrl and bmhi_dpath.
//
// Usage:
//   s_axis carries one request: tuser is the opcode (insert, read slot,
//   clear, no operation); tdata holds key, tag and slot index.
//   m_axis returns exactly one result per request: tuser is the accepted
//   flag; tdata holds the read key, read tag and the entry count after
//   the request.
//   cfg_* writes the capacity register; write it only while the block is idle.
// Sequencing:
//   One request at a time. A clear, no-op, rejected insert or insert into an
//   empty heap goes from decode straight to the finish state; a read first
//   passes through a read-wait state. An insert below the root enters the sift
//   state, which compares with the parent and moves it down for each level the
//   new key climbs, then writes the new key. s_axis_tready returns as the result
//   is registered, even while that result still sits in the output register.
// Reset: entry count clears to zero and capacity returns to 16; slot memory
//   is not cleared. A stalled m_axis holds its result, and a finished request
//   waits until the output register frees up.
`default_nettype none

module binary_max_heap_insert_top #(
  parameter int DEPTH = bmhi_pkg::DEPTH_DEFAULT
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // [31:0] new_key, [47:32] new_tag, [51:48] slot_index, [55:52] zero
  input  wire  [bmhi_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [1:0] opcode
  input  wire  [bmhi_pkg::OP_W-1:0]        s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // [31:0] out_key, [47:32] out_tag, [52:48] entry_count, [55:53] zero
  output logic [bmhi_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // [0] accepted
  output logic                             m_axis_tuser,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [bmhi_pkg::CNT_W-1:0]       cfg_data
);

  bmhi_pkg::cmd_t cmd;
  bmhi_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  bmhi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bmhi_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

endmodule

`default_nettype wire

### rtl/bmhi_ctrl.sv
// Controller for the heap insert block: sequences decode, sift-up and result hand-off.
// Depends on bmhi_pkg; drives bmhi_dpath through cmd_t and reads sts_t.
`default_nettype none

module bmhi_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  bmhi_pkg::sts_t   sts,
  output bmhi_pkg::cmd_t   cmd
);

  bmhi_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmhi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bmhi_pkg::ST_IDLE: begin
        if (in_valid) state_next = bmhi_pkg::ST_DECODE;
      end
      bmhi_pkg::ST_DECODE: begin
        unique case (sts.op)
          bmhi_pkg::OP_INSERT: begin
            if (sts.ins_ok && !sts.pos_zero) state_next = bmhi_pkg::ST_SIFT;
            else state_next = bmhi_pkg::ST_FINISH;
          end
          bmhi_pkg::OP_READ: state_next = bmhi_pkg::ST_READ_WAIT;
          default: state_next = bmhi_pkg::ST_FINISH;
        endcase
      end
      bmhi_pkg::ST_READ_WAIT: state_next = bmhi_pkg::ST_FINISH;
      bmhi_pkg::ST_SIFT: begin
        if (sts.parent_less) begin
          if (sts.parent_zero) state_next = bmhi_pkg::ST_PLACE;
        end else begin
          state_next = bmhi_pkg::ST_FINISH;
        end
      end
      bmhi_pkg::ST_PLACE: state_next = bmhi_pkg::ST_FINISH;
      bmhi_pkg::ST_FINISH: begin
        if (sts.out_free) state_next = bmhi_pkg::ST_IDLE;
      end
      default: state_next = bmhi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      bmhi_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      bmhi_pkg::ST_DECODE: begin
        unique case (sts.op)
          bmhi_pkg::OP_INSERT: begin
            if (sts.ins_ok) begin
              if (sts.pos_zero) cmd.write_new = 1'b1;
              else cmd.read_parent = 1'b1;
            end
          end
          bmhi_pkg::OP_READ:  cmd.read_slot = 1'b1;
          bmhi_pkg::OP_CLEAR: cmd.clear = 1'b1;
          default: ;
        endcase
      end
      bmhi_pkg::ST_SIFT: begin
        if (sts.parent_less) cmd.move_down = 1'b1;
        else cmd.write_new = 1'b1;
      end
      bmhi_pkg::ST_PLACE:  cmd.write_new = 1'b1;
      bmhi_pkg::ST_FINISH: cmd.emit = sts.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/bmhi_dpath.sv
// Datapath for the heap insert block: slot memory, entry count, capacity and result register.
// Depends on bmhi_pkg; commanded by bmhi_ctrl.
`default_nettype none

module bmhi_dpath #(
  parameter int DEPTH = bmhi_pkg::DEPTH_DEFAULT
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire  [bmhi_pkg::IN_DATA_W-1:0]     in_data,
  input  wire  [bmhi_pkg::OP_W-1:0]          in_user,
  input  wire                                cfg_valid,
  input  wire  [bmhi_pkg::CNT_W-1:0]         cfg_data,
  input  bmhi_pkg::cmd_t                     cmd,
  output bmhi_pkg::sts_t                     sts,
  input  wire                                out_ready,
  output logic                               out_valid,
  output logic [bmhi_pkg::OUT_DATA_W-1:0]    out_data,
  output logic                               out_user
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic        [bmhi_pkg::KEY_W-1:0] mem_key [DEPTH];
  logic        [bmhi_pkg::TAG_W-1:0] mem_tag [DEPTH];

  logic        [bmhi_pkg::CNT_W-1:0] capacity;
  logic        [bmhi_pkg::CNT_W-1:0] count;
  bmhi_pkg::op_t                     op;
  logic signed [bmhi_pkg::KEY_W-1:0] new_key;
  logic        [bmhi_pkg::TAG_W-1:0] new_tag;
  logic        [bmhi_pkg::IDX_W-1:0] idx;
  logic        [AW-1:0]              pos;
  logic signed [bmhi_pkg::KEY_W-1:0] rd_key;
  logic        [bmhi_pkg::TAG_W-1:0] rd_tag;
  logic                              acc;

  logic        [AW-1:0]              par;
  logic        [AW-1:0]              gpar;
  logic        [AW-1:0]              rd_addr;
  logic                              rd_en;
  logic                              wr_en;
  logic        [bmhi_pkg::KEY_W-1:0] wr_key;
  logic        [bmhi_pkg::TAG_W-1:0] wr_tag;
  logic                              rd_ok;
  logic        [bmhi_pkg::KEY_W-1:0] res_key;
  logic        [bmhi_pkg::TAG_W-1:0] res_tag;

  assign par  = (pos - AW'(1)) >> 1;
  assign gpar = (par - AW'(1)) >> 1;

  assign rd_en   = cmd.read_parent | cmd.read_slot | cmd.move_down;
  assign rd_addr = cmd.read_slot ? AW'(idx) : (cmd.move_down ? gpar : par);
  assign wr_en   = cmd.write_new | cmd.move_down;
  assign wr_key  = cmd.move_down ? rd_key : new_key;
  assign wr_tag  = cmd.move_down ? rd_tag : new_tag;

  assign rd_ok = ({1'b0, idx} < count) && (32'(idx) < DEPTH);

  assign sts.op          = op;
  assign sts.ins_ok      = (count < capacity) && (32'(count) < DEPTH);
  assign sts.pos_zero    = (pos == '0);
  assign sts.parent_zero = (par == '0);
  assign sts.parent_less = (rd_key < new_key);
  assign sts.out_free    = !out_valid || out_ready;

  assign res_key = (op == bmhi_pkg::OP_READ && acc) ? rd_key : '0;
  assign res_tag = (op == bmhi_pkg::OP_READ && acc) ? rd_tag : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[pos] <= wr_key;
      mem_tag[pos] <= wr_tag;
    end
    if (rd_en) begin
      rd_key <= mem_key[rd_addr];
      rd_tag <= mem_tag[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= bmhi_pkg::CAP_RESET;
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.write_new) begin
      count <= count + bmhi_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= bmhi_pkg::op_t'(in_user);
      new_key <= in_data[bmhi_pkg::KEY_W-1:0];
      new_tag <= in_data[bmhi_pkg::KEY_W +: bmhi_pkg::TAG_W];
      idx     <= in_data[bmhi_pkg::KEY_W + bmhi_pkg::TAG_W +: bmhi_pkg::IDX_W];
      pos     <= AW'(count);
      acc     <= 1'b0;
    end else begin
      if (cmd.move_down) pos <= par;
      if (cmd.write_new) acc <= 1'b1;
      if (cmd.read_slot) acc <= rd_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_user <= acc;
      out_data <= {{bmhi_pkg::OUT_PAD_W{1'b0}}, count, res_tag, res_key};
    end
  end

endmodule

`default_nettype wire

### sim/tb_binary_max_heap_insert_top.sv
// Testbench for binary_max_heap_insert_top: a shadow heap predicts each reply,
// streams run with random gaps and back-pressure, and capacity changes between phases.
// Depends on bmhi_pkg and the RTL of binary_max_heap_insert_top.
`timescale 1ns / 1ps

typedef struct packed {
  logic                        accepted;
  logic [bmhi_pkg::KEY_W-1:0]  key;
  logic [bmhi_pkg::TAG_W-1:0]  tag;
  logic [bmhi_pkg::CNT_W-1:0]  entry_count;
} heap_reply_t;

class heap_tracker;
  logic signed [bmhi_pkg::KEY_W-1:0] slot_key [bmhi_pkg::DEPTH_DEFAULT];
  logic [bmhi_pkg::TAG_W-1:0]        slot_tag [bmhi_pkg::DEPTH_DEFAULT];
  logic [bmhi_pkg::CNT_W-1:0]        fill_count;
  logic [bmhi_pkg::CNT_W-1:0]        capacity;
  heap_reply_t                       pending_replies [$];
  int                                errors;

  function new();
    fill_count = '0;
    capacity   = bmhi_pkg::CAP_RESET;
    errors     = 0;
  endfunction

  function void set_capacity(logic [bmhi_pkg::CNT_W-1:0] value);
    capacity = value;
  endfunction

  function int pending();
    return pending_replies.size();
  endfunction

  // apply one request to the shadow heap and queue the reply it must produce
  function void note_request(bmhi_pkg::op_t op, logic signed [bmhi_pkg::KEY_W-1:0] key,
                             logic [bmhi_pkg::TAG_W-1:0] tag,
                             logic [bmhi_pkg::IDX_W-1:0] idx);
    heap_reply_t                       reply;
    int                                pos;
    int                                parent;
    logic signed [bmhi_pkg::KEY_W-1:0] held_key;
    logic [bmhi_pkg::TAG_W-1:0]        held_tag;
    reply = '0;
    case (op)
      bmhi_pkg::OP_INSERT: begin
        if (fill_count < capacity && fill_count < bmhi_pkg::DEPTH_DEFAULT) begin
          pos = int'(fill_count);
          slot_key[pos] = key;
          slot_tag[pos] = tag;
          while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (slot_key[parent] >= slot_key[pos]) break;
            held_key = slot_key[parent];
            held_tag = slot_tag[parent];
            slot_key[parent] = slot_key[pos];
            slot_tag[parent] = slot_tag[pos];
            slot_key[pos] = held_key;
            slot_tag[pos] = held_tag;
            pos = parent;
          end
          fill_count = fill_count + bmhi_pkg::CNT_W'(1);
          reply.accepted = 1'b1;
        end
      end
      bmhi_pkg::OP_READ: begin
        if (idx < fill_count) begin
          reply.accepted = 1'b1;
          reply.key      = slot_key[idx];
          reply.tag      = slot_tag[idx];
        end
      end
      bmhi_pkg::OP_CLEAR: begin
        fill_count = '0;
      end
      default: ;
    endcase
    reply.entry_count = fill_count;
    pending_replies.push_back(reply);
  endfunction

  function void compare_field(string name, logic [bmhi_pkg::KEY_W-1:0] want,
                              logic [bmhi_pkg::KEY_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_result(logic [bmhi_pkg::OUT_DATA_W-1:0] data, logic acc);
    heap_reply_t want;
    if (pending_replies.size() == 0) begin
      $display("%0t: unexpected reply: expected none, actual accepted %0b data %h",
               $time, acc, data);
      errors++;
      return;
    end
    want = pending_replies.pop_front();
    compare_field("accepted", bmhi_pkg::KEY_W'(want.accepted), bmhi_pkg::KEY_W'(acc));
    compare_field("out_key", want.key, data[bmhi_pkg::KEY_W-1:0]);
    compare_field("out_tag", bmhi_pkg::KEY_W'(want.tag),
                  bmhi_pkg::KEY_W'(data[bmhi_pkg::KEY_W +: bmhi_pkg::TAG_W]));
    compare_field("entry_count", bmhi_pkg::KEY_W'(want.entry_count),
                  bmhi_pkg::KEY_W'(data[bmhi_pkg::KEY_W+bmhi_pkg::TAG_W +: bmhi_pkg::CNT_W]));
  endfunction
endclass

module tb_binary_max_heap_insert_top;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int STALL_CYCLES = 300;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [bmhi_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic [bmhi_pkg::OP_W-1:0]       s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [bmhi_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tuser;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [bmhi_pkg::CNT_W-1:0]      cfg_data;

  heap_tracker heap_sb = new();
  int          send_idle_pct = 7;
  int          recv_idle_pct = 87;
  int          stall_ask = 0;
  int          stall_seen = 0;
  int          stall_left = 0;
  int          cycle_count = 0;

  binary_max_heap_insert_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // hold off on request of the stimulus, otherwise stall at random
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_ask != stall_seen) begin
      stall_seen    <= stall_ask;
      stall_left    <= STALL_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) heap_sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  task automatic send_request(bmhi_pkg::op_t op, logic [bmhi_pkg::KEY_W-1:0] key,
                              logic [bmhi_pkg::TAG_W-1:0] tag,
                              logic [bmhi_pkg::IDX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(bmhi_pkg::IN_DATA_W - bmhi_pkg::KEY_W - bmhi_pkg::TAG_W
                        - bmhi_pkg::IDX_W){1'b0}}, idx, tag, key};
    do @(posedge clk); while (!s_axis_tready);
    heap_sb.note_request(op, key, tag, idx);
  endtask

  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (heap_sb.pending() != 0);
  endtask

  task automatic write_capacity(logic [bmhi_pkg::CNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    heap_sb.set_capacity(value);
  endtask

  function automatic logic [bmhi_pkg::KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3, 4: return bmhi_pkg::KEY_W'($urandom_range(16) - 8);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(int n, bit with_stall);
    int            sel;
    bmhi_pkg::op_t op;
    for (int i = 0; i < n; i++) begin
      if (with_stall && i == n / 2) stall_ask <= stall_ask + 1;
      sel = $urandom_range(99);
      if (sel < 3) op = bmhi_pkg::OP_CLEAR;
      else if (sel < 6) op = bmhi_pkg::OP_NOP;
      else if (sel < 52) op = bmhi_pkg::OP_INSERT;
      else op = bmhi_pkg::OP_READ;
      send_request(op, pick_key(), bmhi_pkg::TAG_W'($urandom_range(65535)),
                   bmhi_pkg::IDX_W'($urandom_range(15)));
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = bmhi_pkg::OP_NOP;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_request(bmhi_pkg::OP_READ, 32'd0, 16'd0, 4'd0);
    send_request(bmhi_pkg::OP_NOP, 32'hffff_ffff, 16'hffff, 4'hf);
    send_request(bmhi_pkg::OP_INSERT, 32'h8000_0000, 16'h0000, 4'd0);
    send_request(bmhi_pkg::OP_INSERT, 32'h7fff_ffff, 16'hffff, 4'hf);
    send_request(bmhi_pkg::OP_INSERT, 32'd5, 16'h0001, 4'd0);
    send_request(bmhi_pkg::OP_INSERT, 32'd5, 16'h0002, 4'd0);
    send_request(bmhi_pkg::OP_INSERT, 32'hffff_ffff, 16'h0003, 4'd0);
    for (int i = 0; i < 4; i++) begin
      send_request(bmhi_pkg::OP_READ, 32'd0, 16'd0, bmhi_pkg::IDX_W'(i));
    end
    send_request(bmhi_pkg::OP_READ, 32'd0, 16'd0, 4'hf);
    send_request(bmhi_pkg::OP_CLEAR, 32'd0, 16'd0, 4'd0);
    send_request(bmhi_pkg::OP_READ, 32'd0, 16'd0, 4'd0);
    send_request(bmhi_pkg::OP_INSERT, 32'd7, 16'haaaa, 4'd0);
    send_request(bmhi_pkg::OP_INSERT, 32'd7, 16'h5555, 4'd0);
    send_request(bmhi_pkg::OP_READ, 32'd0, 16'd0, 4'd1);
    send_request(bmhi_pkg::OP_READ, 32'd0, 16'd0, 4'd0);

    drain_replies();
    write_capacity(5'd2);
    send_request(bmhi_pkg::OP_INSERT, 32'd100, 16'h1234, 4'd0);
    send_request(bmhi_pkg::OP_READ, 32'd0, 16'd0, 4'd1);
    send_request(bmhi_pkg::OP_NOP, 32'd0, 16'd0, 4'd0);
    drain_replies();
    write_capacity(5'd1);
    send_request(bmhi_pkg::OP_INSERT, 32'd200, 16'h4321, 4'd0);
    send_request(bmhi_pkg::OP_READ, 32'd0, 16'd0, 4'd1);
    send_request(bmhi_pkg::OP_CLEAR, 32'd0, 16'd0, 4'd0);
    drain_replies();
    write_capacity(5'd0);
    send_request(bmhi_pkg::OP_INSERT, 32'd300, 16'h0f0f, 4'd0);

    drain_replies();
    write_capacity(5'd15);
    run_random(170, 1'b0);

    drain_replies();
    send_idle_pct = 87;
    recv_idle_pct <= 7;
    write_capacity(bmhi_pkg::CNT_W'($urandom_range(14, 3)));
    run_random(170, 1'b0);

    drain_replies();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    write_capacity(bmhi_pkg::CAP_RESET);
    run_random(170, 1'b1);

    drain_replies();
    repeat (20) @(posedge clk);
    if (heap_sb.errors == 0 && heap_sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
rtl/bmhi_pkg.sv
rtl/bmhi_ctrl.sv
rtl/bmhi_dpath.sv
rtl/binary_max_heap_insert_top.sv
sim/tb_binary_max_heap_insert_top.sv
